// ----- rtl/core/thd_pkg.sv -----
// Package for the teletext Hamming 8/4 and 24/18 decoder.
// Holds the pipeline stage types, operation codes, the 8/4 table and the 24/18 test function.
// No dependencies.
package thd_pkg;

  localparam int CW_W    = 24;
  localparam int VAL_W   = 18;
  localparam int H84_W   = 4;
  localparam int SYN_W   = 6;
  localparam int POS_W   = 5;

  localparam logic OP_HAM84   = 1'b0;
  localparam logic OP_HAM2418 = 1'b1;

  localparam logic [7:0]       H84_INVALID = 8'hFF;
  localparam int               SYN_BIAS    = 33;
  localparam logic [SYN_W-1:0] SYN_TOP     = 6'd32;
  localparam logic [POS_W-1:0] SYN_PASS    = 5'h1F;
  localparam logic [POS_W-1:0] SYN_REF     = 5'd30;

  localparam logic [7:0] H84_TABLE [256] = '{
    8'h01,8'hff,8'h01,8'h01,8'hff,8'h00,8'h01,8'hff,8'hff,8'h02,8'h01,8'hff,8'h0a,8'hff,8'hff,8'h07,
    8'hff,8'h00,8'h01,8'hff,8'h00,8'h00,8'hff,8'h00,8'h06,8'hff,8'hff,8'h0b,8'hff,8'h00,8'h03,8'hff,
    8'hff,8'h0c,8'h01,8'hff,8'h04,8'hff,8'hff,8'h07,8'h06,8'hff,8'hff,8'h07,8'hff,8'h07,8'h07,8'h07,
    8'h06,8'hff,8'hff,8'h05,8'hff,8'h00,8'h0d,8'hff,8'h06,8'h06,8'h06,8'hff,8'h06,8'hff,8'hff,8'h07,
    8'hff,8'h02,8'h01,8'hff,8'h04,8'hff,8'hff,8'h09,8'h02,8'h02,8'hff,8'h02,8'hff,8'h02,8'h03,8'hff,
    8'h08,8'hff,8'hff,8'h05,8'hff,8'h00,8'h03,8'hff,8'hff,8'h02,8'h03,8'hff,8'h03,8'hff,8'h03,8'h03,
    8'h04,8'hff,8'hff,8'h05,8'h04,8'h04,8'h04,8'hff,8'hff,8'h02,8'h0f,8'hff,8'h04,8'hff,8'hff,8'h07,
    8'hff,8'h05,8'h05,8'h05,8'h04,8'hff,8'hff,8'h05,8'h06,8'hff,8'hff,8'h05,8'hff,8'h0e,8'h03,8'hff,
    8'hff,8'h0c,8'h01,8'hff,8'h0a,8'hff,8'hff,8'h09,8'h0a,8'hff,8'hff,8'h0b,8'h0a,8'h0a,8'h0a,8'hff,
    8'h08,8'hff,8'hff,8'h0b,8'hff,8'h00,8'h0d,8'hff,8'hff,8'h0b,8'h0b,8'h0b,8'h0a,8'hff,8'hff,8'h0b,
    8'h0c,8'h0c,8'hff,8'h0c,8'hff,8'h0c,8'h0d,8'hff,8'hff,8'h0c,8'h0f,8'hff,8'h0a,8'hff,8'hff,8'h07,
    8'hff,8'h0c,8'h0d,8'hff,8'h0d,8'hff,8'h0d,8'h0d,8'h06,8'hff,8'hff,8'h0b,8'hff,8'h0e,8'h0d,8'hff,
    8'h08,8'hff,8'hff,8'h09,8'hff,8'h09,8'h09,8'h09,8'hff,8'h02,8'h0f,8'hff,8'h0a,8'hff,8'hff,8'h09,
    8'h08,8'h08,8'h08,8'hff,8'h08,8'hff,8'hff,8'h09,8'h08,8'hff,8'hff,8'h0b,8'hff,8'h0e,8'h03,8'hff,
    8'hff,8'h0c,8'h0f,8'hff,8'h04,8'hff,8'hff,8'h09,8'h0f,8'hff,8'h0f,8'h0f,8'hff,8'h0e,8'h0f,8'hff,
    8'h08,8'hff,8'hff,8'h05,8'hff,8'h0e,8'h0d,8'hff,8'hff,8'h0e,8'h0f,8'hff,8'h0e,8'h0e,8'hff,8'h0e
  };

  typedef struct packed {
    logic             op;
    logic [CW_W-1:0]  cw;
    logic [SYN_W-1:0] syn;
    logic [H84_W-1:0] h84_val;
    logic             h84_bad;
  } syn_stage_t;

  typedef struct packed {
    logic             op;
    logic [CW_W-1:0]  cw;
    logic             bad24;
    logic [H84_W-1:0] h84_val;
    logic             h84_bad;
  } fix_stage_t;

  // Parity tests A..F folded into one word: bit i adds (i + 33), the top bit adds 32.
  function automatic logic [SYN_W-1:0] h2418_tests(input logic [CW_W-1:0] cw);
    logic [SYN_W-1:0] t;
    t = '0;
    for (int i = 0; i < CW_W - 1; i++) begin
      if (cw[i]) t = t ^ SYN_W'(i + SYN_BIAS);
    end
    if (cw[CW_W-1]) t = t ^ SYN_TOP;
    return t;
  endfunction

endpackage

// ----- rtl/core/thd_if.sv -----
// Request and response channel interfaces for the teletext Hamming decoder.
// Depends on thd_pkg for field widths.
interface thd_req_if import thd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            operation;
  logic [CW_W-1:0] codeword;

  modport source (output valid, operation, codeword, input ready);
  modport sink   (input valid, operation, codeword, output ready);
endinterface

interface thd_rsp_if import thd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] decoded_value;
  logic             uncorrectable;

  modport source (output valid, decoded_value, uncorrectable, input ready);
  modport sink   (input valid, decoded_value, uncorrectable, output ready);
endinterface

// ----- rtl/core/thd_syndrome.sv -----
// Stage one: 8/4 table lookup and 24/18 parity test word.
// Depends on thd_pkg.
module thd_syndrome import thd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            operation,
  input  logic [CW_W-1:0] codeword,
  output logic            out_valid,
  input  logic            out_ready,
  output syn_stage_t      out_data
);

  logic [7:0] entry;
  syn_stage_t data_next;

  assign in_ready = !out_valid || out_ready;
  assign entry    = H84_TABLE[codeword[7:0]];

  always_comb begin
    data_next.op      = operation;
    data_next.cw      = codeword;
    data_next.syn     = h2418_tests(codeword);
    data_next.h84_bad = (entry == H84_INVALID);
    data_next.h84_val = (entry == H84_INVALID) ? '0 : entry[H84_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/core/thd_correct.sv -----
// Stage two: 24/18 double error flag and single bit correction.
// Depends on thd_pkg.
module thd_correct import thd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  syn_stage_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output fix_stage_t out_data
);

  logic             fail;
  logic [POS_W-1:0] pos;
  logic [CW_W-1:0]  flip;
  fix_stage_t       data_next;

  assign in_ready = !out_valid || out_ready;
  // low five tests not all passing; with test F failing the word is 0..30
  assign fail     = (in_data.syn[POS_W-1:0] != SYN_PASS);
  assign pos      = SYN_REF - in_data.syn[POS_W-1:0];
  // positions above 23 shift the bit out, leaving the data untouched
  assign flip     = CW_W'(1) << pos;

  always_comb begin
    data_next.op      = in_data.op;
    data_next.h84_val = in_data.h84_val;
    data_next.h84_bad = in_data.h84_bad;
    data_next.bad24   = fail && in_data.syn[SYN_W-1];
    data_next.cw      = (fail && !in_data.syn[SYN_W-1]) ?
                        (in_data.cw ^ flip) : in_data.cw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/core/thd_pack.sv -----
// Stage three: data bit packing, result select and output register.
// Depends on thd_pkg.
module thd_pack import thd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fix_stage_t       in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] decoded_value,
  output logic             uncorrectable
);

  logic [VAL_W-1:0] packed_val;
  logic [VAL_W-1:0] val_next;
  logic             bad_next;

  assign in_ready   = !out_valid || out_ready;
  assign packed_val = {in_data.cw[22:16], in_data.cw[14:8], in_data.cw[6:4], in_data.cw[2]};

  always_comb begin
    case (in_data.op)
      OP_HAM84: begin
        val_next = VAL_W'(in_data.h84_val);
        bad_next = in_data.h84_bad;
      end
      OP_HAM2418: begin
        val_next = in_data.bad24 ? '0 : packed_val;
        bad_next = in_data.bad24;
      end
      default: begin
        val_next = '0;
        bad_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      decoded_value <= val_next;
      uncorrectable <= bad_next;
    end
  end

endmodule

// ----- rtl/core/teletext_hamming_decoder_core.sv -----
// Top level of the teletext Hamming 8/4 and 24/18 decoder.
// Depends on thd_pkg, thd_if, thd_syndrome, thd_correct and thd_pack.
//
// Usage:
//   req carries one request: operation (0 = 8/4 byte in codeword[7:0],
//   1 = 24/18 triplet in codeword[23:0]). rsp returns decoded_value and
//   uncorrectable for each request, in order, exactly once.
//   A request is taken when valid and ready are both high on a rising edge.
// Pipeline: three register stages from request to response valid (table/test word,
//   correction, packing).
// Throughput: one request per cycle, sustained, while rsp.ready is high.
// Stall: a stage holds its item while the next one is full and stalled;
//   empty stages still fill, so up to three requests are taken during a
//   stall before req.ready drops. Nothing is lost or repeated.
// Reset: rst (synchronous) empties all stages; req.ready is high the cycle
//   after and no response is shown until a new request passes through.
module teletext_hamming_decoder_core import thd_pkg::*; (
  input  logic clk,
  input  logic rst,
  thd_req_if.sink   req,
  thd_rsp_if.source rsp
);

  logic       s1_valid;
  logic       s1_ready;
  syn_stage_t s1_data;
  logic       s2_valid;
  logic       s2_ready;
  fix_stage_t s2_data;

  thd_syndrome u_syndrome (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .operation (req.operation),
    .codeword  (req.codeword),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  thd_correct u_correct (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  thd_pack u_pack (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s2_valid),
    .in_ready      (s2_ready),
    .in_data       (s2_data),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .decoded_value (rsp.decoded_value),
    .uncorrectable (rsp.uncorrectable)
  );

endmodule

// ----- bench/tb_teletext_hamming_decoder_core.sv -----
`timescale 1ns / 100ps
// Self-checking bench for teletext_hamming_decoder_core: directed and random 8/4 bytes and
// 24/18 triplets (clean, single, double and random errors) under random stalls on both sides.
// Depends on thd_pkg, thd_if and the decoder RTL.
module tb_teletext_hamming_decoder_core import thd_pkg::*; ();

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [7:0] BYTE_LUT [256] = '{
    8'h01,8'hff,8'h01,8'h01,8'hff,8'h00,8'h01,8'hff,8'hff,8'h02,8'h01,8'hff,8'h0a,8'hff,8'hff,8'h07,
    8'hff,8'h00,8'h01,8'hff,8'h00,8'h00,8'hff,8'h00,8'h06,8'hff,8'hff,8'h0b,8'hff,8'h00,8'h03,8'hff,
    8'hff,8'h0c,8'h01,8'hff,8'h04,8'hff,8'hff,8'h07,8'h06,8'hff,8'hff,8'h07,8'hff,8'h07,8'h07,8'h07,
    8'h06,8'hff,8'hff,8'h05,8'hff,8'h00,8'h0d,8'hff,8'h06,8'h06,8'h06,8'hff,8'h06,8'hff,8'hff,8'h07,
    8'hff,8'h02,8'h01,8'hff,8'h04,8'hff,8'hff,8'h09,8'h02,8'h02,8'hff,8'h02,8'hff,8'h02,8'h03,8'hff,
    8'h08,8'hff,8'hff,8'h05,8'hff,8'h00,8'h03,8'hff,8'hff,8'h02,8'h03,8'hff,8'h03,8'hff,8'h03,8'h03,
    8'h04,8'hff,8'hff,8'h05,8'h04,8'h04,8'h04,8'hff,8'hff,8'h02,8'h0f,8'hff,8'h04,8'hff,8'hff,8'h07,
    8'hff,8'h05,8'h05,8'h05,8'h04,8'hff,8'hff,8'h05,8'h06,8'hff,8'hff,8'h05,8'hff,8'h0e,8'h03,8'hff,
    8'hff,8'h0c,8'h01,8'hff,8'h0a,8'hff,8'hff,8'h09,8'h0a,8'hff,8'hff,8'h0b,8'h0a,8'h0a,8'h0a,8'hff,
    8'h08,8'hff,8'hff,8'h0b,8'hff,8'h00,8'h0d,8'hff,8'hff,8'h0b,8'h0b,8'h0b,8'h0a,8'hff,8'hff,8'h0b,
    8'h0c,8'h0c,8'hff,8'h0c,8'hff,8'h0c,8'h0d,8'hff,8'hff,8'h0c,8'h0f,8'hff,8'h0a,8'hff,8'hff,8'h07,
    8'hff,8'h0c,8'h0d,8'hff,8'h0d,8'hff,8'h0d,8'h0d,8'h06,8'hff,8'hff,8'h0b,8'hff,8'h0e,8'h0d,8'hff,
    8'h08,8'hff,8'hff,8'h09,8'hff,8'h09,8'h09,8'h09,8'hff,8'h02,8'h0f,8'hff,8'h0a,8'hff,8'hff,8'h09,
    8'h08,8'h08,8'h08,8'hff,8'h08,8'hff,8'hff,8'h09,8'h08,8'hff,8'hff,8'h0b,8'hff,8'h0e,8'h03,8'hff,
    8'hff,8'h0c,8'h0f,8'hff,8'h04,8'hff,8'hff,8'h09,8'h0f,8'hff,8'h0f,8'h0f,8'hff,8'h0e,8'h0f,8'hff,
    8'h08,8'hff,8'hff,8'h05,8'hff,8'h0e,8'h0d,8'hff,8'hff,8'h0e,8'h0f,8'hff,8'h0e,8'h0e,8'hff,8'h0e
  };

  logic clk;
  logic rst;
  logic idle_on;
  int   cycles = 0;
  int   stall_left;

  thd_req_if req_ch ();
  thd_rsp_if rsp_ch ();

  teletext_hamming_decoder_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Parity tests A..F: bit i below 23 toggles 32 + (i + 1), bit 23 toggles 32 only.
  function automatic logic [SYN_W-1:0] triplet_tests(logic [CW_W-1:0] w);
    logic [SYN_W-1:0] t;
    t = '0;
    for (int i = 0; i < CW_W - 1; i++) begin
      if (w[i]) t ^= {1'b1, 5'(i + 1)};
    end
    if (w[CW_W-1]) t ^= {1'b1, 5'd0};
    return t;
  endfunction

  // Clean triplet: all tests pass, so the word is 6'h3F.
  function automatic logic [CW_W-1:0] build_triplet(logic [VAL_W-1:0] d);
    logic [CW_W-1:0]  w;
    logic [SYN_W-1:0] t;
    logic [4:0]       fix;
    w = '0;
    w[2]     = d[0];
    w[6:4]   = d[3:1];
    w[14:8]  = d[10:4];
    w[22:16] = d[17:11];
    t   = triplet_tests(w);
    fix = t[4:0] ^ SYN_PASS;
    w[0]  = fix[0];
    w[1]  = fix[1];
    w[3]  = fix[2];
    w[7]  = fix[3];
    w[15] = fix[4];
    t     = triplet_tests(w);
    w[23] = ~t[5];
    return w;
  endfunction

  class hamming_scoreboard;
    logic [VAL_W-1:0] value_q[$];
    logic             bad_q[$];
    int errors;
    int byte_reqs;
    int triplet_reqs;
    int bad_seen;
    int checked;

    function new();
      errors = 0;
      byte_reqs = 0;
      triplet_reqs = 0;
      bad_seen = 0;
      checked = 0;
    endfunction

    function void note_request(logic op, logic [CW_W-1:0] cw);
      logic [VAL_W-1:0] v;
      logic             b;
      logic [7:0]       e;
      logic [SYN_W-1:0] t;
      logic [CW_W-1:0]  w;
      int               idx;
      v = '0;
      b = 1'b0;
      if (op == OP_HAM84) begin
        byte_reqs++;
        e = BYTE_LUT[cw[7:0]];
        if (e == H84_INVALID) b = 1'b1;
        else v = VAL_W'(e[3:0]);
      end else begin
        triplet_reqs++;
        w = cw;
        t = triplet_tests(w);
        if (t[4:0] != SYN_PASS && t[5]) begin
          b = 1'b1;
        end else begin
          if (t[4:0] != SYN_PASS) begin
            idx = 30 - int'(t);
            if (idx < CW_W) w[idx] = ~w[idx];
          end
          v = {w[22:16], w[14:8], w[6:4], w[2]};
        end
      end
      value_q.push_back(v);
      bad_q.push_back(b);
    endfunction

    function void check_result(logic [VAL_W-1:0] v, logic b);
      logic [VAL_W-1:0] ev;
      logic             eb;
      if (value_q.size() == 0) begin
        $display("%0t: unexpected response, got value %h uncorrectable %b", $time, v, b);
        errors++;
      end else begin
        ev = value_q.pop_front();
        eb = bad_q.pop_front();
        checked++;
        if (eb) bad_seen++;
        if (v !== ev) begin
          $display("%0t: decoded_value expected %h, got %h", $time, ev, v);
          errors++;
        end
        if (b !== eb) begin
          $display("%0t: uncorrectable expected %b, got %b", $time, eb, b);
          errors++;
        end
      end
    endfunction

    function int pending();
      return value_q.size();
    endfunction
  endclass

  hamming_scoreboard sb;

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      sb.note_request(req_ch.operation, req_ch.codeword);
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_result(rsp_ch.decoded_value, rsp_ch.uncorrectable);
  end

  task automatic send_request(logic op, logic [CW_W-1:0] cw);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.codeword  <= cw;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic send_triplet_variant(logic [VAL_W-1:0] d, int kind);
    logic [CW_W-1:0] w;
    int              k1;
    int              k2;
    w  = build_triplet(d);
    k1 = $urandom_range(0, CW_W - 1);
    k2 = (k1 + $urandom_range(1, CW_W - 1)) % CW_W;
    if (kind >= 1) w[k1] = ~w[k1];
    if (kind >= 2) w[k2] = ~w[k2];
    send_request(OP_HAM2418, w);
  endtask

  task automatic run_random(int n);
    int kind;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        send_request(OP_HAM84, CW_W'($urandom));
      end else begin
        kind = $urandom_range(0, 9);
        if (kind <= 3) send_triplet_variant(VAL_W'($urandom), 0);
        else if (kind <= 6) send_triplet_variant(VAL_W'($urandom), 1);
        else if (kind <= 8) send_triplet_variant(VAL_W'($urandom), 2);
        else send_request(OP_HAM2418, CW_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [CW_W-1:0] w;
    sb = new();
    idle_on <= 1'b1;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.operation <= OP_HAM84;
    req_ch.codeword <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // byte decode: extremes, invalid entries, high bits ignored
    send_request(OP_HAM84, 24'h000000);
    send_request(OP_HAM84, 24'h0000FF);
    send_request(OP_HAM84, 24'hFFFF00);
    send_request(OP_HAM84, 24'hFFFFFF);
    send_request(OP_HAM84, 24'h000001);
    send_request(OP_HAM84, 24'h5A5A15);
    send_request(OP_HAM84, 24'hA5A5EA);
    // triplets: raw extremes, clean words, single errors incl. bit 23 and parity bits
    send_request(OP_HAM2418, 24'h000000);
    send_request(OP_HAM2418, 24'hFFFFFF);
    send_request(OP_HAM2418, build_triplet('0));
    send_request(OP_HAM2418, build_triplet('1));
    send_request(OP_HAM2418, build_triplet(18'h2AAAA));
    w = build_triplet(18'h15555);
    send_request(OP_HAM2418, w ^ 24'h000001);
    send_request(OP_HAM2418, w ^ 24'h800000);
    send_request(OP_HAM2418, w ^ 24'h008000);
    send_request(OP_HAM2418, w ^ 24'h400000);
    send_request(OP_HAM2418, w ^ 24'h000004);
    // double errors
    send_request(OP_HAM2418, w ^ 24'h000005);
    send_request(OP_HAM2418, w ^ 24'h810000);
    send_request(OP_HAM2418, build_triplet('1) ^ 24'h000300);

    run_random(250);
    idle_on <= 1'b0;
    run_random(100);
    idle_on <= 1'b1;
    run_random(250);
    idle_on <= 1'b0;
    run_random(100);
    req_ch.valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d responses: %0d byte and %0d triplet requests, %0d uncorrectable.",
             sb.checked, sb.byte_reqs, sb.triplet_reqs, sb.bad_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
